// ===== sv/calclk_pkg.sv =====
package calclk_pkg;

  typedef enum logic [0:0] {
    KIND_TICK = 1'b0,
    KIND_SET  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  set_second;
    logic [5:0]  set_minute;
    logic [4:0]  set_hour;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [13:0] set_year;
  } in_t;

  typedef struct packed {
    logic [5:0]  now_second;
    logic [5:0]  now_minute;
    logic [4:0]  now_hour;
    logic [4:0]  now_day;
    logic [3:0]  now_month;
    logic [13:0] now_year;
    logic        leap_flag;
  } out_t;

  localparam logic [5:0]  SecondMax = 6'd59;
  localparam logic [5:0]  MinuteMax = 6'd59;
  localparam logic [4:0]  HourMax   = 5'd23;
  localparam logic [3:0]  MonthMax  = 4'd12;
  localparam logic [13:0] YearWrap  = 14'd9999;
  localparam logic [13:0] YearLast  = 14'd9998;
  localparam logic [13:0] YearReset = 14'd2000;

  // 25 * Inv25 == 1 mod 2**14; y is a multiple of 25 iff y * Inv25 (mod 2**14) <= Div25Lim
  localparam logic [13:0] Inv25    = 14'd7209;
  localparam logic [13:0] Div25Lim = 14'd655;

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    prod  = 28'(y) * 28'(Inv25);
    div25 = (prod[13:0] <= Div25Lim);
    // leap: divisible by 4, and either not by 100 or also by 400
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [13:0] year_inc(input logic [13:0] y);
    return (y >= YearLast) ? 14'd0 : y + 14'd1;
  endfunction

endpackage

// ===== sv/calendar_clock_counter_core.sv =====
// From input transfer to result an item passes the input register, then the time/date register.
// Throughput: one item per cycle; the carry chain and the leap test fit between the two
// registers, so a new item may enter every cycle while the output is not stalled.
// Reset: time clears to 00:00:00, date to 2000-01-01; both stages empty.
// Every item yields one result holding the time after the item and the leap flag.
module calendar_clock_counter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  calclk_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output calclk_pkg::out_t  out_data_o
);

  logic             in_valid_q, in_valid_d;
  calclk_pkg::in_t  in_q;
  logic             out_valid_q, out_valid_d;
  logic [5:0]       sec_q, sec_d;
  logic [5:0]       min_q, min_d;
  logic [4:0]       hour_q, hour_d;
  logic [4:0]       day_q, day_d;
  logic [3:0]       month_q, month_d;
  logic [13:0]      year_q, year_d;

  logic in_acc;
  logic adv;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // next time and date from the held item
  always_comb begin
    logic [6:0]  s;
    logic [6:0]  mi;
    logic [5:0]  h;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [13:0] y0;
    logic        lp;
    logic [4:0]  len;
    logic        day_inc;
    if (in_q.kind == calclk_pkg::KIND_SET) begin
      y0 = (in_q.set_year >= calclk_pkg::YearWrap) ? 14'd0 : in_q.set_year;
      if (in_q.set_month == 4'd0) begin
        m = 4'd1;
        y = y0;
      end else if (in_q.set_month > calclk_pkg::MonthMax) begin
        m = 4'd1;
        y = calclk_pkg::year_inc(y0);
      end else begin
        m = in_q.set_month;
        y = y0;
      end
      d  = (in_q.set_day == 5'd0) ? 5'd1 : in_q.set_day;
      s  = {1'b0, in_q.set_second};
      mi = {1'b0, in_q.set_minute};
      h  = {1'b0, in_q.set_hour};
    end else begin
      y0 = year_q;
      y  = year_q;
      m  = month_q;
      d  = day_q;
      s  = {1'b0, sec_q} + 7'd1;
      mi = {1'b0, min_q};
      h  = {1'b0, hour_q};
    end
    lp  = calclk_pkg::is_leap(y);
    len = calclk_pkg::month_len(m, lp);
    // a set day past the month end rolls into the next month; December never overflows
    if (d > len) begin
      d = 5'd1;
      m = m + 4'd1;
    end
    if (s > {1'b0, calclk_pkg::SecondMax}) begin
      s  = 7'd0;
      mi = mi + 7'd1;
    end
    if (mi > {1'b0, calclk_pkg::MinuteMax}) begin
      mi = 7'd0;
      h  = h + 6'd1;
    end
    day_inc = (h > {1'b0, calclk_pkg::HourMax});
    if (day_inc) begin
      h = 6'd0;
      if (d >= len) begin
        d = 5'd1;
        if (m >= calclk_pkg::MonthMax) begin
          m = 4'd1;
          y = calclk_pkg::year_inc(y);
        end else begin
          m = m + 4'd1;
        end
      end else begin
        d = d + 5'd1;
      end
    end
    sec_d   = s[5:0];
    min_d   = mi[5:0];
    hour_d  = h[4:0];
    day_d   = d;
    month_d = m;
    year_d  = y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sec_q       <= 6'd0;
      min_q       <= 6'd0;
      hour_q      <= 5'd0;
      day_q       <= 5'd1;
      month_q     <= 4'd1;
      year_q      <= calclk_pkg::YearReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        sec_q   <= sec_d;
        min_q   <= min_d;
        hour_q  <= hour_d;
        day_q   <= day_d;
        month_q <= month_d;
        year_q  <= year_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.now_second = sec_q;
  assign out_data_o.now_minute = min_q;
  assign out_data_o.now_hour   = hour_q;
  assign out_data_o.now_day    = day_q;
  assign out_data_o.now_month  = month_q;
  assign out_data_o.now_year   = year_q;
  assign out_data_o.leap_flag  = calclk_pkg::is_leap(year_q);

  // stored time and date always stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= calclk_pkg::SecondMax && min_q <= calclk_pkg::MinuteMax &&
    hour_q <= calclk_pkg::HourMax && year_q < calclk_pkg::YearWrap)
    else $error("time or year out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_q >= 5'd1 && month_q >= 4'd1 && month_q <= calclk_pkg::MonthMax &&
    day_q <= calclk_pkg::month_len(month_q, calclk_pkg::is_leap(year_q)))
    else $error("date out of range");

  // state moves only when an item passes into the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sec_q) && $stable(min_q) && $stable(hour_q) &&
             $stable(day_q) && $stable(month_q) && $stable(year_q))
    else $error("state changed without a transfer");

  // a tick below the minute boundary only advances the second
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.kind == calclk_pkg::KIND_TICK && sec_q != calclk_pkg::SecondMax
    |=> sec_q == $past(sec_q) + 6'd1 && $stable(min_q))
    else $error("tick did not advance the second");

endmodule
